// File: rtl/ryuv_pkg.sv
// ---------------------------------------------------------------------------
// ryuv_pkg
// Shared widths, register indexes and fixed-point constants for the
// RGB to packed YUV 4:2:2 converter with differential update.
// ---------------------------------------------------------------------------
package ryuv_pkg;

  // Field widths of the pixel and macropixel channels.
  localparam int PIXEL_INDEX_W = 16;
  localparam int COMP_W        = 8;
  localparam int MACROPIXEL_W  = 32;
  localparam int RGB_W         = 3 * COMP_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_UYVY_ORDER        = 1'b0,
    CFG_DIFFERENTIAL_MODE = 1'b1
  } cfg_index_t;

  // Default frame store depth.
  localparam int FRAME_PIXELS_DEFAULT = 65536;

  // BT.601 luma weights in Q16, rounded to nearest; they sum to 1.0.
  localparam logic [15:0] KY_R = 16'd19595;
  localparam logic [15:0] KY_G = 16'd38470;
  localparam logic [15:0] KY_B = 16'd7471;

  // Blue weight of (B - Y) and red weight of (R - Y), in Q16.
  localparam logic [15:0] KB_DIFF = 16'd58065;
  localparam logic [15:0] KR_DIFF = 16'd45941;

  // Chroma scales 0.493 and 0.877 in Q16.
  localparam logic [15:0] KU = 16'd32309;
  localparam logic [15:0] KV = 16'd57475;

endpackage

// File: rtl/ryuv_ifs.sv
// ---------------------------------------------------------------------------
// ryuv_pix_if / ryuv_mp_if
// Valid/ready channels: RGB pixels in, packed macropixels out.
// ---------------------------------------------------------------------------
interface ryuv_pix_if import ryuv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PIXEL_INDEX_W-1:0] pixel_index;
  logic [COMP_W-1:0]        red;
  logic [COMP_W-1:0]        green;
  logic [COMP_W-1:0]        blue;
  logic                     full_refresh;

  modport source (
    output valid, pixel_index, red, green, blue, full_refresh,
    input  ready
  );
  modport sink (
    input  valid, pixel_index, red, green, blue, full_refresh,
    output ready
  );
endinterface

interface ryuv_mp_if import ryuv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    changed;
  logic [MACROPIXEL_W-1:0] macropixel;

  modport source (
    output valid, changed, macropixel,
    input  ready
  );
  modport sink (
    input  valid, changed, macropixel,
    output ready
  );
endinterface

// File: rtl/rgb_to_packed_yuv422_diff.sv
// ---------------------------------------------------------------------------
// rgb_to_packed_yuv422_diff
// Converts RGB pixels to BT.601 YUV and packs each into a 4-byte YUY2 or
// UYVY macropixel. A frame store of the previous pixels lets the block
// skip unchanged pixels in differential mode.
// ---------------------------------------------------------------------------
// A pixel moves through stages 0 to 4 and then the output register.
// Throughput: one pixel per cycle; the six-stage pipeline moves as a whole
// and stops only while the output register holds a beat that is not taken.
// The frame store is one memory with a registered read and one write port,
// and a same-address write in flight is forwarded to the following pixel.
// Reset clears the stage valid bits and both configuration registers; the
// frame store is not cleared and its entries are undefined until written.
module rgb_to_packed_yuv422_diff import ryuv_pkg::*; #(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ryuv_pix_if.sink               pix,
  ryuv_mp_if.source              mp
);

  // Frame store addressing and the reciprocal used to wrap the index.
  localparam int LOG_FP      = $clog2(FRAME_PIXELS);
  localparam int ADDR_W      = (FRAME_PIXELS > 1) ? LOG_FP : 1;
  localparam int RECIP_SHIFT = PIXEL_INDEX_W + LOG_FP;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS);
  localparam int RECIP_W     = PIXEL_INDEX_W + 1;
  localparam int PROD_W      = PIXEL_INDEX_W + RECIP_W;
  localparam int FP_W        = 21;
  localparam int QFP_W       = PIXEL_INDEX_W + FP_W;

  // Truncate a Q32 chroma value toward zero, clamp to -128..127, add 128.
  function automatic logic [7:0] chroma_byte(input logic signed [41:0] q);
    logic signed [10:0] t;
    t = $signed({q[41], q[41:32]}) + $signed({10'b0, q[41] & (|q[31:0])});
    if (t > 11'sd127) begin
      return 8'hFF;
    end else if (t < -11'sd128) begin
      return 8'h00;
    end else begin
      return {~t[7], t[6:0]};
    end
  endfunction

  // Configuration registers.
  logic uyvy_order;
  logic differential_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      uyvy_order        <= 1'b0;
      differential_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UYVY_ORDER:        uyvy_order        <= cfg_data[0];
        CFG_DIFFERENTIAL_MODE: differential_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output beat is stalled.
  logic adv;
  logic stall;
  logic v0, v1, v2, v3, v4;

  assign stall     = mp.valid && !mp.ready;
  assign adv       = !stall;
  assign pix.ready = adv;

  // Stage 0 payload: input fields and the reciprocal product of the index.
  logic [PIXEL_INDEX_W-1:0] idx0;
  logic [RGB_W-1:0]         rgb0;
  logic                     fr0;
  logic [PROD_W-1:0]        prod0;

  // Stage 1 payload: wrapped frame address.
  logic [ADDR_W-1:0]        addr1;
  logic [RGB_W-1:0]         rgb1;
  logic                     fr1;
  logic [PIXEL_INDEX_W-1:0] quot1;
  logic [QFP_W-1:0]         qfp1;
  logic [PIXEL_INDEX_W-1:0] rem1;

  // Stage 2 payload: stored pixel read back, with a forwarded write.
  logic [ADDR_W-1:0]        addr2;
  logic [RGB_W-1:0]         rgb2;
  logic                     fr2;
  logic [RGB_W-1:0]         mem_q;
  logic                     fwd_hit;
  logic [RGB_W-1:0]         fwd_data;
  logic [RGB_W-1:0]         prev2;
  logic                     skip2;
  logic                     mem_we;

  // Stage 3 payload: luma and the two unscaled color differences.
  logic                     changed3;
  logic [23:0]              y3;
  logic [24:0]              du3;
  logic [24:0]              dv3;

  // Stage 4 payload: luma byte and Q32 chroma products.
  logic                     changed4;
  logic [COMP_W-1:0]        yb4;
  logic signed [41:0]       pu4;
  logic signed [41:0]       pv4;

  // Output register.
  logic                     changed5;
  logic [MACROPIXEL_W-1:0]  word5;
  logic [MACROPIXEL_W-1:0]  word_next;
  logic [COMP_W-1:0]        ub4;
  logic [COMP_W-1:0]        vb4;

  logic [RGB_W-1:0]         frame_mem [FRAME_PIXELS];

  // Index wrap: quotient by reciprocal, then remainder by one multiply.
  assign quot1 = PIXEL_INDEX_W'(prod0 >> RECIP_SHIFT);
  assign qfp1  = QFP_W'(quot1) * QFP_W'(FRAME_PIXELS);
  assign rem1  = idx0 - PIXEL_INDEX_W'(qfp1);

  // Compare with the stored pixel; unchanged pixels skip in differential mode.
  assign prev2  = fwd_hit ? fwd_data : mem_q;
  assign skip2  = differential_mode && !fr2 && (prev2 == rgb2);
  assign mem_we = adv && v2 && !skip2;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      mp.valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (adv) begin
      v0       <= pix.valid;
      v1       <= v0;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      mp.valid <= v4;
      fwd_hit  <= mem_we && (addr2 == addr1);
    end
  end

  // Frame store: registered read for the pixel entering stage 2, write-back
  // from stage 2. A same-edge write to that address is caught by fwd_hit.
  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= frame_mem[addr1];
    end
    if (mem_we) begin
      frame_mem[addr2] <= rgb2;
    end
  end

  // Chroma bytes from the stage 4 products.
  assign ub4 = chroma_byte(pu4);
  assign vb4 = chroma_byte(pv4);

  // Byte packing; a skipped pixel gives an all-zero word.
  always_comb begin
    if (!changed4) begin
      word_next = '0;
    end else if (uyvy_order) begin
      word_next = {yb4, vb4, yb4, ub4};
    end else begin
      word_next = {vb4, yb4, ub4, yb4};
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 0.
      idx0     <= pix.pixel_index;
      rgb0     <= {pix.red, pix.green, pix.blue};
      fr0      <= pix.full_refresh;
      prod0    <= PROD_W'(pix.pixel_index) * PROD_W'(RECIP);
      // Stage 1.
      addr1    <= ADDR_W'(rem1);
      rgb1     <= rgb0;
      fr1      <= fr0;
      // Stage 2.
      addr2    <= addr1;
      rgb2     <= rgb1;
      fr2      <= fr1;
      fwd_data <= rgb2;
      // Stage 3: luma and (B - Y), (R - Y) in Q16, wrapping in 25 bits.
      changed3 <= !skip2;
      y3       <= 24'(KY_R) * 24'(rgb2[23:16]) + 24'(KY_G) * 24'(rgb2[15:8])
                + 24'(KY_B) * 24'(rgb2[7:0]);
      du3      <= 25'(KB_DIFF) * 25'(rgb2[7:0]) - 25'(KY_R) * 25'(rgb2[23:16])
                - 25'(KY_G) * 25'(rgb2[15:8]);
      dv3      <= 25'(KR_DIFF) * 25'(rgb2[23:16]) - 25'(KY_G) * 25'(rgb2[15:8])
                - 25'(KY_B) * 25'(rgb2[7:0]);
      // Stage 4: chroma scale multiplies.
      changed4 <= changed3;
      yb4      <= y3[23:16];
      pu4      <= $signed(du3) * $signed({1'b0, KU});
      pv4      <= $signed(dv3) * $signed({1'b0, KV});
      // Output register.
      changed5 <= changed4;
      word5    <= word_next;
    end
  end

  assign mp.changed    = changed5;
  assign mp.macropixel = word5;

  // A stalled output freezes every stage.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(stall)) |-> $stable({v0, v1, v2, v3, v4}))
    else $error("pipeline moved while the output beat was stalled");

  // A frame store write belongs to a converted pixel in stage 3 next.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (v3 && changed3))
    else $error("frame store written for a pixel that was not converted");

  // A skipped pixel carries an all-zero macropixel.
  assert property (@(posedge clk) disable iff (rst)
    (mp.valid && !mp.changed) |-> (mp.macropixel == '0))
    else $error("skipped pixel with a nonzero macropixel");

  // Luma appears twice in every converted macropixel.
  assert property (@(posedge clk) disable iff (rst)
    (mp.valid && mp.changed) |->
      ((mp.macropixel[7:0] == mp.macropixel[23:16]) ||
       (mp.macropixel[15:8] == mp.macropixel[31:24])))
    else $error("luma bytes of a macropixel differ");

endmodule

// File: bench/tb_rgb_to_packed_yuv422_diff.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_to_packed_yuv422_diff
// Self-checking bench for the RGB to packed YUV 4:2:2 converter. A short
// table of directed pixels covers the color extremes, both packing orders,
// and skipped, forced and same-address pixels. Random pixel streams follow
// under every register setting. Each macropixel beat is checked against a
// typed table value, else a bench fixed-point conversion and frame store.
// ---------------------------------------------------------------------------
module tb_rgb_to_packed_yuv422_diff;
  import ryuv_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 64;
  localparam int SEG_PIXELS    = 57;

  typedef struct packed {
    logic [PIXEL_INDEX_W-1:0] pixel_index;
    logic [COMP_W-1:0]        red;
    logic [COMP_W-1:0]        green;
    logic [COMP_W-1:0]        blue;
    logic                     full_refresh;
  } pix_item_t;

  typedef struct packed {
    logic                    changed;
    logic [MACROPIXEL_W-1:0] macropixel;
  } mp_beat_t;

  // A directed expectation typed into the table, when it has one.
  typedef struct packed {
    bit       known;
    mp_beat_t beat;
  } typed_beat_t;

  typedef struct packed {
    bit        uyvy;
    bit        diff;
    pix_item_t item;
    bit        known;
    mp_beat_t  beat;
  } pix_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ryuv_pix_if pix ();
  ryuv_mp_if  mp ();

  rgb_to_packed_yuv422_diff u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .mp        (mp)
  );

  always #HALF_PERIOD clk = ~clk;

  wire pix_beat = pix.valid && pix.ready;
  wire mp_beat  = mp.valid && mp.ready;

  // Bench copy of the registers and of the frame store.
  bit                 pack_uyvy;
  bit                 skip_unchanged;
  bit [RGB_W-1:0]     stored_rgb [FRAME_PIXELS_DEFAULT];

  // Expected macropixel beats, oldest first, and table expectations.
  mp_beat_t           macropixel_q [$];
  typed_beat_t        typed_beats_q [$];

  // Pixels already offered, so differential compares only hit written entries.
  bit [RGB_W-1:0]     sent_rgb [int unsigned];
  bit [PIXEL_INDEX_W-1:0] touched_idx [$];
  bit [PIXEL_INDEX_W-1:0] last_index;

  int unsigned        src_idle_pct;
  int unsigned        sink_idle_pct;
  bit                 hold_req;
  int                 errors;
  int                 pixels_in;
  int                 converted_n;
  int                 skipped_n;
  int                 quiet;

  // Directed rows: extremes, both orders, skips, forced refresh, same address.
  pix_row_t directed_rows [24] = '{
    '{1'b0, 1'b0, '{16'd0,     8'd0,    8'd0,    8'd0,    1'b0}, 1'b1, '{1'b1, 32'h8000_8000}},
    '{1'b0, 1'b0, '{16'd65535, 8'd255,  8'd255,  8'd255,  1'b0}, 1'b1, '{1'b1, 32'h80FF_80FF}},
    '{1'b0, 1'b0, '{16'd1,     8'd255,  8'd0,    8'd0,    1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b0, '{16'd2,     8'd0,    8'd0,    8'd255,  1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b0, '{16'd3,     8'd0,    8'd255,  8'd255,  1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b0, '{16'd4,     8'd255,  8'd255,  8'd0,    1'b1}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b0, '{16'd5,     8'd0,    8'd255,  8'd0,    1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b0, '{16'd6,     8'h55,   8'hAA,   8'h33,   1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b1, 1'b0, '{16'd7,     8'd0,    8'd0,    8'd0,    1'b0}, 1'b1, '{1'b1, 32'h0080_0080}},
    '{1'b1, 1'b0, '{16'd8,     8'd255,  8'd255,  8'd255,  1'b0}, 1'b1, '{1'b1, 32'hFF80_FF80}},
    '{1'b1, 1'b0, '{16'd9,     8'hAA,   8'h55,   8'hCC,   1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd0,     8'd0,    8'd0,    8'd0,    1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd0,     8'd0,    8'd0,    8'd0,    1'b1}, 1'b1, '{1'b1, 32'h0080_0080}},
    '{1'b1, 1'b1, '{16'd65535, 8'd255,  8'd255,  8'd255,  1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd65535, 8'd255,  8'd255,  8'd254,  1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd65535, 8'd255,  8'd255,  8'd254,  1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd1,     8'd255,  8'd0,    8'd0,    1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd1,     8'd0,    8'd0,    8'd0,    1'b0}, 1'b1, '{1'b1, 32'h0080_0080}},
    '{1'b1, 1'b1, '{16'd1,     8'd0,    8'd0,    8'd0,    1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b1, 1'b1, '{16'd100,   8'd12,   8'd34,   8'd56,   1'b1}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b1, '{16'd100,   8'd12,   8'd34,   8'd56,   1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b0, 1'b1, '{16'd2,     8'd0,    8'd0,    8'd255,  1'b0}, 1'b1, '{1'b0, 32'h0}},
    '{1'b0, 1'b1, '{16'd2,     8'd0,    8'd1,    8'd255,  1'b0}, 1'b0, '{1'b0, 32'h0}},
    '{1'b0, 1'b0, '{16'd2,     8'd0,    8'd1,    8'd255,  1'b0}, 1'b0, '{1'b0, 32'h0}}
  };

  // Truncate a Q32 chroma value toward zero, saturate it to a signed byte
  // and add the 128 offset.
  function automatic logic [COMP_W-1:0] sat_chroma(input longint q32);
    longint whole;
    whole = (q32 < 0) ? -((-q32) >>> 32) : (q32 >>> 32);
    if (whole > 127) whole = 127;
    else if (whole < -128) whole = -128;
    return COMP_W'(whole + 128);
  endfunction

  // Expected beat for one accepted pixel; updates the bench frame store.
  function automatic mp_beat_t convert_pixel(input pix_item_t it);
    mp_beat_t          res;
    logic [RGB_W-1:0]  rgb;
    longint            luma_q16;
    logic [COMP_W-1:0] y_b;
    logic [COMP_W-1:0] u_b;
    logic [COMP_W-1:0] v_b;
    rgb = {it.red, it.green, it.blue};
    if (skip_unchanged && !it.full_refresh && stored_rgb[it.pixel_index] == rgb) begin
      res.changed    = 1'b0;
      res.macropixel = '0;
      return res;
    end
    stored_rgb[it.pixel_index] = rgb;
    luma_q16 = longint'(KY_R) * longint'(it.red) + longint'(KY_G) * longint'(it.green)
             + longint'(KY_B) * longint'(it.blue);
    y_b = ((luma_q16 >>> 16) > 255) ? 8'd255 : COMP_W'(luma_q16 >>> 16);
    u_b = sat_chroma((longint'(it.blue) * 65536 - luma_q16) * longint'(KU));
    v_b = sat_chroma((longint'(it.red) * 65536 - luma_q16) * longint'(KV));
    res.changed    = 1'b1;
    res.macropixel = pack_uyvy ? {y_b, v_b, y_b, u_b} : {v_b, y_b, u_b, y_b};
    return res;
  endfunction

  // Color component biased toward the extremes.
  function automatic logic [COMP_W-1:0] random_component();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  // Random pixel: mostly revisits of written entries, often unchanged,
  // sometimes one bit off, plus back-to-back hits on the same address.
  task automatic pick_pixel(output pix_item_t it);
    int unsigned    roll;
    bit [RGB_W-1:0] rgb;
    roll = $urandom_range(99);
    it.full_refresh = ($urandom_range(9) == 0);
    if (roll < 20) begin
      it.pixel_index = last_index;
    end else if (roll < 75) begin
      it.pixel_index = touched_idx[$urandom_range(touched_idx.size() - 1)];
    end else begin
      it.pixel_index = PIXEL_INDEX_W'($urandom);
    end
    if (!sent_rgb.exists(it.pixel_index)) begin
      // In differential mode a never-written entry is only reached through a forced write.
      rgb = {random_component(), random_component(), random_component()};
      if (skip_unchanged) it.full_refresh = 1'b1;
    end else if ($urandom_range(99) < 55) begin
      rgb = sent_rgb[it.pixel_index];
      if ($urandom_range(2) == 0) rgb ^= RGB_W'(1) << $urandom_range(RGB_W - 1);
    end else begin
      rgb = {random_component(), random_component(), random_component()};
    end
    {it.red, it.green, it.blue} = rgb;
  endtask

  // Offer one pixel beat, with random gaps, and return once it is accepted.
  task automatic offer_pixel(input pix_item_t it, input bit known, input mp_beat_t want);
    typed_beats_q.push_back(typed_beat_t'{known, want});
    if (!sent_rgb.exists(it.pixel_index)) touched_idx.push_back(it.pixel_index);
    sent_rgb[it.pixel_index] = {it.red, it.green, it.blue};
    last_index = it.pixel_index;
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid        <= 1'b1;
    pix.pixel_index  <= it.pixel_index;
    pix.red          <= it.red;
    pix.green        <= it.green;
    pix.blue         <= it.blue;
    pix.full_refresh <= it.full_refresh;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected beat has come out.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (macropixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles.
  task automatic apply_settings(input bit uyvy, input bit diff);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UYVY_ORDER;
    cfg_data  <= uyvy;
    @(posedge clk);
    cfg_index <= CFG_DIFFERENTIAL_MODE;
    cfg_data  <= diff;
    @(posedge clk);
    cfg_we         <= 1'b0;
    pack_uyvy      = uyvy;
    skip_unchanged = diff;
  endtask

  // Receiver: random ready, and one long hold-off on request.
  initial begin
    mp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        mp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Predict on each pixel beat, check each macropixel beat.
  always @(posedge clk) begin
    mp_beat_t    want;
    typed_beat_t note;
    if (!rst && pix_beat) begin
      want = convert_pixel(pix_item_t'{pix.pixel_index, pix.red, pix.green, pix.blue,
                                       pix.full_refresh});
      if (typed_beats_q.size() != 0) begin
        note = typed_beats_q.pop_front();
        if (note.known) want = note.beat;
      end
      macropixel_q.push_back(want);
      pixels_in++;
    end
    if (!rst && mp_beat) begin
      if (macropixel_q.size() == 0) begin
        $display("%0t: macropixel beat with none expected: expected none, actual %0b/%08h",
                 $time, mp.changed, mp.macropixel);
        errors++;
      end else begin
        want = macropixel_q.pop_front();
        if (mp.changed !== want.changed) begin
          $display("%0t: changed mismatch: expected %0b, actual %0b",
                   $time, want.changed, mp.changed);
          errors++;
        end
        if (mp.macropixel !== want.macropixel) begin
          $display("%0t: macropixel mismatch: expected %08h, actual %08h",
                   $time, want.macropixel, mp.macropixel);
          errors++;
        end
        if (want.changed) converted_n++;
        else skipped_n++;
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || pix_beat || mp_beat) quiet = 0;
      else quiet++;
    end
    $display("FAIL rgb_to_packed_yuv422_diff");
    $finish;
  end

  // Main sequence: reset, directed table, then random segments.
  initial begin
    pix_item_t it;
    mp_beat_t  no_beat;
    cfg_we           = 1'b0;
    cfg_index        = CFG_UYVY_ORDER;
    cfg_data         = '0;
    pix.valid        = 1'b0;
    pix.pixel_index  = '0;
    pix.red          = '0;
    pix.green        = '0;
    pix.blue         = '0;
    pix.full_refresh = 1'b0;
    hold_req         = 1'b0;
    pack_uyvy        = 1'b0;
    skip_unchanged   = 1'b0;
    no_beat          = '0;
    src_idle_pct     = 17;
    sink_idle_pct    = 71;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The first rows run on the reset values of the registers.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].uyvy != pack_uyvy || directed_rows[i].diff != skip_unchanged) begin
        wait_idle();
        apply_settings(directed_rows[i].uyvy, directed_rows[i].diff);
      end
      offer_pixel(directed_rows[i].item, directed_rows[i].known, directed_rows[i].beat);
    end

    // Three idling profiles, each through all four register settings.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
      sink_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle();
        apply_settings(seg[0], seg[1]);
        // Fill the pipeline against a stalled receiver once.
        if (ph == 2 && seg == 0) hold_req <= 1'b1;
        repeat (SEG_PIXELS) begin
          pick_pixel(it);
          offer_pixel(it, 1'b0, no_beat);
        end
      end
    end
    wait_idle();

    $display("Run covered %0d pixel beats: %0d converted, %0d skipped.",
             pixels_in, converted_n, skipped_n);
    $display("Both packing orders, differential mode on and off, and a long output stall.");
    if (errors == 0) begin
      $display("PASS rgb_to_packed_yuv422_diff");
    end else begin
      $display("FAIL rgb_to_packed_yuv422_diff");
    end
    $finish;
  end

endmodule
